### hdl/plfr_pkg.sv
`timescale 1ns / 1ps

package plfr_pkg;

    // Item modes
    localparam logic [2:0] MODE_CLEAR    = 3'd0;
    localparam logic [2:0] MODE_KEY      = 3'd1;
    localparam logic [2:0] MODE_END_KEY  = 3'd2;
    localparam logic [2:0] MODE_TEXT     = 3'd3;
    localparam logic [2:0] MODE_END_TEXT = 3'd4;

    localparam int GRID_SIDE  = 5;
    localparam int GRID_CELLS = 25;
    localparam int ALPHA_LEN  = 26;

    localparam logic [4:0] IDX_I       = 5'd8;
    localparam logic [4:0] IDX_J       = 5'd9;
    localparam logic [4:0] IDX_Z       = 5'd25;
    localparam logic [4:0] PAD_RESET   = 5'd23;
    localparam logic [4:0] LAST_LETTER = 5'd25;

    localparam logic [6:0] ASCII_A = 7'd65;
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    // Register index decoded from paddr[2]
    localparam logic REG_PAD = 1'b0;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    typedef struct packed {
        logic    take;        // item accepted this cycle
        logic    walk_en;     // end-of-key fill step
        letter_t walk_letter; // letter tried by the fill step
        logic    load;        // move looked-up pair into output buffer
    } cmd_t;

    typedef struct packed {
        logic pair_req;   // item on the input makes a cipher pair
        logic end_key;    // item on the input is end of key
        logic buf_empty;  // output buffer drained
    } sts_t;

    function automatic coord_t cell_row(cell_t c);
        coord_t r;
        if (c < 5'd5)       r = 3'd0;
        else if (c < 5'd10) r = 3'd1;
        else if (c < 5'd15) r = 3'd2;
        else if (c < 5'd20) r = 3'd3;
        else                r = 3'd4;
        return r;
    endfunction

    function automatic cell_t row_base(coord_t r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic coord_t cell_col(cell_t c);
        cell_t d;
        d = c - row_base(cell_row(c));
        return d[2:0];
    endfunction

    function automatic cell_t cell_at(coord_t r, coord_t c);
        return row_base(r) + {2'b00, c};
    endfunction

    function automatic coord_t wrap_next(coord_t v);
        return (v == 3'(GRID_SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

### hdl/plfr_ctrl.sv
`timescale 1ns / 1ps

module plfr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  plfr_pkg::sts_t sts,
    output plfr_pkg::cmd_t cmd
);
    import plfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_MAP,
        ST_LOAD
    } state_t;

    state_t  state_reg, state_next;
    letter_t walk_reg, walk_next;
    logic    ready_reg;

    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        cmd              = '0;
        cmd.walk_letter  = walk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.take = item_valid && ready_reg;
                if (cmd.take)
                begin
                    if (sts.end_key)
                    begin
                        state_next = ST_FILL;
                        walk_next  = '0;
                    end
                    else if (sts.pair_req)
                    begin
                        state_next = ST_MAP;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.walk_en = 1'b1;
                if (walk_reg == LAST_LETTER)
                    state_next = ST_IDLE;
                else
                    walk_next = walk_reg + 5'd1;
            end
            ST_MAP:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // wait for the previous pair to drain
                if (sts.buf_empty)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign item_ready = ready_reg;

endmodule

### hdl/plfr_datapath.sv
`timescale 1ns / 1ps

module plfr_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [2:0]     mode,
    input  logic [7:0]     symbol,
    input  logic [4:0]     pad_letter,
    input  plfr_pkg::cmd_t cmd,
    output plfr_pkg::sts_t sts,
    input  logic           result_ready,
    output logic           result_valid,
    output logic [6:0]     cipher_letter,
    output logic           pair_second,
    output logic           message_done
);
    import plfr_pkg::*;

    localparam logic [ALPHA_LEN-1:0] USED_RESET = ALPHA_LEN'(1) << IDX_J;

    // grid stores
    letter_t letter_at_cell_mem [GRID_CELLS];
    cell_t   cell_of_letter_mem [ALPHA_LEN];

    logic [ALPHA_LEN-1:0] used_reg, used_next;
    cell_t                fill_reg, fill_next;
    letter_t              held_letter_reg, held_letter_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 pend_done_reg, pend_done_next;
    logic [1:0]           ob_cnt_reg, ob_cnt_next;

    cell_t   ca_reg, cb_reg;
    letter_t la_reg, lb_reg;
    letter_t ob0_reg, ob1_reg;
    logic    ob_done_reg;

    letter_t sym_letter;
    logic    sym_ok;
    letter_t pad_idx;
    letter_t rd_a, rd_b;
    letter_t place_letter;
    logic    place_try, place_en;
    coord_t  r1, c1, r2, c2;
    cell_t   o1, o2;
    letter_t out_sel;

    // normalize the input byte
    always_comb
    begin
        sym_letter = '0;
        sym_ok     = 1'b0;
        if (symbol >= UPPER_A && symbol <= UPPER_Z)
        begin
            sym_ok     = 1'b1;
            sym_letter = 5'(symbol - UPPER_A);
        end
        else if (symbol >= LOWER_A && symbol <= LOWER_Z)
        begin
            sym_ok     = 1'b1;
            sym_letter = 5'(symbol - LOWER_A);
        end
        if (sym_letter == IDX_J)
            sym_letter = IDX_I;
    end

    // pad clamps to Z, J folds to I
    always_comb
    begin
        pad_idx = (pad_letter > IDX_Z) ? IDX_Z : pad_letter;
        if (pad_idx == IDX_J)
            pad_idx = IDX_I;
    end

    assign sts.pair_req  = held_valid_reg &&
                           ((mode == MODE_TEXT && sym_ok) || mode == MODE_END_TEXT);
    assign sts.end_key   = (mode == MODE_END_KEY);
    assign sts.buf_empty = (ob_cnt_reg == 2'd0);

    assign rd_a = held_letter_reg;
    assign rd_b = (mode == MODE_TEXT && sym_letter != held_letter_reg) ? sym_letter : pad_idx;

    // key placement
    assign place_letter = cmd.walk_en ? cmd.walk_letter : sym_letter;
    assign place_try    = cmd.walk_en || (cmd.take && mode == MODE_KEY && sym_ok);
    assign place_en     = place_try && !used_reg[place_letter] &&
                          (fill_reg < 5'(GRID_CELLS));

    always_comb
    begin
        used_next        = used_reg;
        fill_next        = fill_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        pend_done_next   = pend_done_reg;
        ob_cnt_next      = ob_cnt_reg;

        if (place_en)
        begin
            used_next[place_letter] = 1'b1;
            fill_next               = fill_reg + 5'd1;
        end

        if (cmd.take)
        begin
            pend_done_next = (mode == MODE_END_TEXT);
            case (mode)
                MODE_CLEAR:
                begin
                    used_next       = USED_RESET;
                    fill_next       = '0;
                    held_valid_next = 1'b0;
                end
                MODE_TEXT:
                begin
                    if (sym_ok)
                    begin
                        if (!held_valid_reg)
                        begin
                            held_letter_next = sym_letter;
                            held_valid_next  = 1'b1;
                        end
                        else if (sym_letter != held_letter_reg)
                        begin
                            held_valid_next = 1'b0;
                        end
                    end
                end
                MODE_END_TEXT:
                begin
                    held_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.load)
            ob_cnt_next = 2'd2;
        else if (result_valid && result_ready)
            ob_cnt_next = ob_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= USED_RESET;
            fill_reg        <= '0;
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            pend_done_reg   <= 1'b0;
            ob_cnt_reg      <= '0;
        end
        else
        begin
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            pend_done_reg   <= pend_done_next;
            ob_cnt_reg      <= ob_cnt_next;
        end
    end

    // cell lookup, registered at accept
    always_ff @(posedge clk)
    begin
        if (place_en)
            cell_of_letter_mem[place_letter] <= fill_reg;
        if (cmd.take)
        begin
            ca_reg <= cell_of_letter_mem[rd_a];
            cb_reg <= cell_of_letter_mem[rd_b];
        end
    end

    // row, column and rectangle rules
    always_comb
    begin
        r1 = cell_row(ca_reg);
        c1 = cell_col(ca_reg);
        r2 = cell_row(cb_reg);
        c2 = cell_col(cb_reg);
        if (r1 == r2)
        begin
            o1 = cell_at(r1, wrap_next(c1));
            o2 = cell_at(r2, wrap_next(c2));
        end
        else if (c1 == c2)
        begin
            o1 = cell_at(wrap_next(r1), c1);
            o2 = cell_at(wrap_next(r2), c2);
        end
        else
        begin
            o1 = cell_at(r1, c2);
            o2 = cell_at(r2, c1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (place_en)
            letter_at_cell_mem[fill_reg] <= place_letter;
        la_reg <= letter_at_cell_mem[o1];
        lb_reg <= letter_at_cell_mem[o2];
    end

    // two-entry output buffer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ob0_reg     <= la_reg;
            ob1_reg     <= lb_reg;
            ob_done_reg <= pend_done_reg;
        end
    end

    assign out_sel       = (ob_cnt_reg == 2'd2) ? ob0_reg : ob1_reg;
    assign result_valid  = (ob_cnt_reg != 2'd0);
    assign cipher_letter = ASCII_A + {2'b00, out_sel};
    assign pair_second   = (ob_cnt_reg == 2'd1);
    assign message_done  = pair_second && ob_done_reg;

endmodule

### hdl/playfair_cipher_encryptor_unit.sv
`timescale 1ns / 1ps
// Clear key, key byte and non-pairing text items are taken back to back.
// End key: an accept, then a walk over A..Z in the fill sequencer.
// Pairing text or end text steps through accept/cell lookup, grid read and buffer load;
//   the load waits while the previous pair drains, one letter per transaction.
// Reset (rst_n, async, active low) clears control, key usage, fill count and
//   the open pair; pad_letter returns to X. Grid stores are not cleared.
module playfair_cipher_encryptor_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  mode,
    input  logic [7:0]  symbol,
    // result items
    output logic        result_valid,
    input  logic        result_ready,
    output logic [6:0]  cipher_letter,
    output logic        pair_second,
    output logic        message_done
);
    import plfr_pkg::*;

    logic [4:0] pad_reg;
    logic       cfg_wr;
    cmd_t       cmd;
    sts_t       sts;

    // pad_letter register at byte address 0; write completes in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= PAD_RESET;
        else if (cfg_wr && paddr[2] == REG_PAD)
            pad_reg <= pwdata[4:0];
    end

    assign prdata = (paddr[2] == REG_PAD) ? {27'b0, pad_reg} : 32'b0;

    // sequencer: accepts items, walks end-of-key fill, steps the pair lookup
    plfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // grid stores, pair state, lookup rules and output buffer
    plfr_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .symbol        (symbol),
        .pad_letter    (pad_reg),
        .cmd           (cmd),
        .sts           (sts),
        .result_ready  (result_ready),
        .result_valid  (result_valid),
        .cipher_letter (cipher_letter),
        .pair_second   (pair_second),
        .message_done  (message_done)
    );

endmodule

### hdl/plfr_checker.sv
`timescale 1ns / 1ps

module plfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic [2:0] mode,
    input logic       result_valid,
    input logic       result_ready,
    input logic [6:0] cipher_letter,
    input logic       pair_second,
    input logic       message_done
);
    import plfr_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(cipher_letter) && $stable(pair_second))
        else $error("result changed while stalled");

    // first letter of a pair is followed by its second letter
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !pair_second |=> result_valid && pair_second)
        else $error("second letter missing after first");

    // done only on the second letter
    a_done_second: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && message_done |-> pair_second)
        else $error("message_done on first letter");

    // end of key blocks input while the grid fills
    a_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && mode == MODE_END_KEY |=> !item_ready)
        else $error("input taken during key fill");

endmodule

bind playfair_cipher_encryptor_unit plfr_checker u_plfr_checker (.*);
